>>> hw/rtl/lkv_pkg.sv
// Package for the LRU key/value cache: field widths, operation codes,
// the result record and reset constants. No dependencies.
`timescale 1ns / 1ps

package lkv_pkg;

	localparam int KEY_W           = 32;
	localparam int VAL_W           = 32;
	localparam int CAP_W           = 5;
	localparam int ENTRIES_DEFAULT = 16;
	localparam int DATA_IN_W       = 64;
	localparam int RES_W           = 1 + VAL_W + 1 + KEY_W;
	localparam int DATA_OUT_W      = 72;

	localparam logic [CAP_W-1:0] CAP_RESET  = 5'd16;
	localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0] evicted_key;
		logic             evicted;
		logic [VAL_W-1:0] read_value;
		logic             found;
	} lkv_result_t;

endpackage

>>> hw/rtl/lkv_store.sv
// Entry storage: key and value memories plus the recency rank memory,
// each with one write port and one registered read port. Uses lkv_pkg.
`timescale 1ns / 1ps

module lkv_store import lkv_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEFAULT,
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	localparam int AW = IW
) (
	input  logic             clk,
	input  logic             kv_rd_en,
	input  logic [IW-1:0]    kv_rd_addr,
	output logic [KEY_W-1:0] kv_rd_key,
	output logic [VAL_W-1:0] kv_rd_value,
	input  logic             kv_wr_en,
	input  logic [IW-1:0]    kv_wr_addr,
	input  logic [KEY_W-1:0] kv_wr_key,
	input  logic [VAL_W-1:0] kv_wr_value,
	input  logic             age_rd_en,
	input  logic [IW-1:0]    age_rd_addr,
	output logic [AW-1:0]    age_rd_data,
	input  logic             age_wr_en,
	input  logic [IW-1:0]    age_wr_addr,
	input  logic [AW-1:0]    age_wr_data
);

	logic [KEY_W-1:0] key_mem [ENTRIES];
	logic [VAL_W-1:0] val_mem [ENTRIES];
	logic [AW-1:0]    age_mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (kv_wr_en) begin
			key_mem[kv_wr_addr] <= kv_wr_key;
			val_mem[kv_wr_addr] <= kv_wr_value;
		end
		if (kv_rd_en) begin
			kv_rd_key   <= key_mem[kv_rd_addr];
			kv_rd_value <= val_mem[kv_rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (age_wr_en) begin
			age_mem[age_wr_addr] <= age_wr_data;
		end
		if (age_rd_en) begin
			age_rd_data <= age_mem[age_rd_addr];
		end
	end

endmodule

>>> hw/rtl/lkv_ctrl.sv
// Sequencer for the LRU key/value cache: scan pass, decision, rank update
// pass, valid bits, occupancy and capacity register. Uses lkv_pkg.
`timescale 1ns / 1ps

module lkv_ctrl import lkv_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEFAULT,
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
	localparam int AW = IW,
	localparam int CW = $clog2(ENTRIES + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CAP_W-1:0]     cfg_wr_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [DATA_IN_W-1:0] s_tdata,
	input  logic                 s_tuser,
	output logic                 kv_rd_en,
	output logic [IW-1:0]        kv_rd_addr,
	input  logic [KEY_W-1:0]     kv_rd_key,
	input  logic [VAL_W-1:0]     kv_rd_value,
	output logic                 kv_wr_en,
	output logic [IW-1:0]        kv_wr_addr,
	output logic [KEY_W-1:0]     kv_wr_key,
	output logic [VAL_W-1:0]     kv_wr_value,
	output logic                 age_rd_en,
	output logic [IW-1:0]        age_rd_addr,
	input  logic [AW-1:0]        age_rd_data,
	output logic                 age_wr_en,
	output logic [IW-1:0]        age_wr_addr,
	output logic [AW-1:0]        age_wr_data,
	output logic                 res_push,
	output lkv_result_t          res_data,
	input  logic                 res_ready
);

	localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_DECIDE = 5'b00100,
		ST_AGE    = 5'b01000,
		ST_DONE   = 5'b10000
	} lkv_state_t;

	lkv_state_t         state_q;
	logic [CW-1:0]      cnt_q;
	logic [ENTRIES-1:0] valid_q;
	logic [CW-1:0]      occ_q;
	logic [CAP_W-1:0]   cap_q;

	logic               op_q;
	logic [KEY_W-1:0]   key_q;
	logic [VAL_W-1:0]   val_q;
	logic               hit_q;
	logic [IW-1:0]      hit_idx_q;
	logic [AW-1:0]      hit_age_q;
	logic [VAL_W-1:0]   hit_val_q;
	logic               any_q;
	logic [AW-1:0]      best_q;
	logic [IW-1:0]      victim_q;
	logic [KEY_W-1:0]   victim_key_q;
	logic               free_q;
	logic [IW-1:0]      free_idx_q;
	logic               touch_q;
	logic [IW-1:0]      zero_idx_q;
	lkv_result_t        res_q;

	logic               s_accept;
	logic               cnt_issue;
	logic               cnt_last;
	logic               rsp_live;
	logic [IW-1:0]      rsp_idx;
	logic               rsp_valid;
	logic               is_put;
	logic [CMPW-1:0]    cap_ext;
	logic [CMPW-1:0]    cap_eff;
	logic               need_evict;
	logic               drop_new;
	logic [IW-1:0]      slot;
	logic               do_insert;

	assign s_tready  = (state_q == ST_IDLE);
	assign s_accept  = s_tvalid && s_tready;
	assign cnt_issue = (cnt_q < CW'(ENTRIES));
	assign cnt_last  = (cnt_q == CW'(ENTRIES));
	assign rsp_live  = (cnt_q != '0);
	assign rsp_idx   = IW'(cnt_q - 1'b1);
	assign rsp_valid = valid_q[rsp_idx];
	assign is_put    = (op_q == OP_PUT);

	assign cap_ext    = CMPW'(cap_q);
	assign cap_eff    = (cap_ext > CMPW'(ENTRIES)) ? CMPW'(ENTRIES) : cap_ext;
	assign need_evict = (CMPW'(occ_q) >= cap_eff);
	assign drop_new   = need_evict && (occ_q == '0);
	assign do_insert  = is_put && !hit_q && !drop_new;
	assign slot = (need_evict && !(free_q && (free_idx_q < victim_q))) ? victim_q : free_idx_q;

	assign kv_rd_en    = (state_q == ST_SCAN) && cnt_issue;
	assign kv_rd_addr  = cnt_q[IW-1:0];
	assign age_rd_en   = ((state_q == ST_SCAN) || (state_q == ST_AGE)) && cnt_issue;
	assign age_rd_addr = cnt_q[IW-1:0];

	assign kv_wr_en    = (state_q == ST_DECIDE) && ((hit_q && is_put) || do_insert);
	assign kv_wr_addr  = hit_q ? hit_idx_q : slot;
	assign kv_wr_key   = key_q;
	assign kv_wr_value = val_q;

	assign age_wr_en   = (state_q == ST_AGE) && rsp_live;
	assign age_wr_addr = rsp_idx;

	always_comb begin
		if (rsp_idx == zero_idx_q) begin
			age_wr_data = '0;
		end else if (rsp_valid && (!touch_q || (age_rd_data < hit_age_q))) begin
			age_wr_data = AW'(age_rd_data + 1'b1);
		end else begin
			age_wr_data = age_rd_data;
		end
	end

	assign res_push = (state_q == ST_DONE);
	assign res_data = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			valid_q <= '0;
			occ_q   <= '0;
			cap_q   <= CAP_RESET;
		end else begin
			if (cfg_wr_en) begin
				cap_q <= cfg_wr_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (s_accept) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_last) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					cnt_q <= '0;
					if (hit_q) begin
						state_q <= ST_AGE;
					end else if (do_insert) begin
						state_q <= ST_AGE;
						if (need_evict) begin
							valid_q <= (valid_q & ~(ENTRIES'(1) << victim_q))
								| (ENTRIES'(1) << slot);
						end else begin
							occ_q <= occ_q + 1'b1;
							valid_q[slot] <= 1'b1;
						end
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_AGE: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			op_q   <= s_tuser;
			key_q  <= s_tdata[KEY_W-1:0];
			val_q  <= s_tdata[KEY_W +: VAL_W];
			hit_q  <= 1'b0;
			any_q  <= 1'b0;
			free_q <= 1'b0;
		end
		if ((state_q == ST_SCAN) && rsp_live) begin
			if (rsp_valid && (kv_rd_key == key_q)) begin
				hit_q     <= 1'b1;
				hit_idx_q <= rsp_idx;
				hit_age_q <= age_rd_data;
				hit_val_q <= kv_rd_value;
			end
			if (rsp_valid && (!any_q || (age_rd_data >= best_q))) begin
				any_q        <= 1'b1;
				best_q       <= age_rd_data;
				victim_q     <= rsp_idx;
				victim_key_q <= kv_rd_key;
			end
			if (!rsp_valid && !free_q) begin
				free_q     <= 1'b1;
				free_idx_q <= rsp_idx;
			end
		end
		if (state_q == ST_DECIDE) begin
			touch_q    <= hit_q;
			zero_idx_q <= hit_q ? hit_idx_q : slot;
			res_q <= '{
				evicted_key: (is_put && !hit_q && need_evict) ?
					(drop_new ? key_q : victim_key_q) : '0,
				evicted:     is_put && !hit_q && need_evict,
				read_value:  (hit_q && !is_put) ? hit_val_q : MISS_VALUE,
				found:       hit_q
			};
		end
	end

`ifndef NO_ASSERTIONS
	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == CW'($countones(valid_q)))
		else $error("occupancy does not match the number of valid entries");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CW'(ENTRIES))
		else $error("occupancy above the entry count");

	a_accept_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> (state_q == ST_SCAN))
		else $error("accepted transaction did not start a scan");

	a_no_hit_evict: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> !(res_q.found && res_q.evicted))
		else $error("a hit reported an eviction");

	a_age_after_decide: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_AGE) |-> ($past(state_q) == ST_DECIDE))
		else $error("rank update pass entered without a decision");
`endif

endmodule

>>> hw/rtl/lkv_out.sv
// Output register for the LRU key/value cache result stream.
// Holds one result so the sequencer can take the next transaction. Uses lkv_pkg.
`timescale 1ns / 1ps

module lkv_out import lkv_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  res_push,
	input  lkv_result_t           res_data,
	output logic                  res_ready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [DATA_OUT_W-1:0] m_tdata
);

	logic        out_valid_q;
	lkv_result_t out_data_q;

	assign res_ready = !out_valid_q || m_tready;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {{(DATA_OUT_W - RES_W){1'b0}}, out_data_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_push && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push && res_ready) begin
			out_data_q <= res_data;
		end
	end

endmodule

>>> hw/rtl/lru_key_value_cache.sv
// Usage: a fully associative key/value cache with least-recently-used
// replacement. Input transactions arrive on the s_ stream: s_tuser selects
// get or put, s_tdata carries the key and the value. Each transaction
// yields exactly one result transaction on the m_ stream.
// The capacity register is written through cfg_wr_en and cfg_wr_data; the
// user must write it only while the block is idle, which the block does not
// enforce. Capacities above ENTRIES act as ENTRIES. A transaction walks all
// ENTRIES slots through one memory read port to find a hit, the victim and
// a free slot, then walks them again to rewrite the recency ranks. Hits and
// insertions take both walks; get misses and puts dropped at capacity zero
// skip the second walk. The sequencer hands the result to the output
// register, which drives m_tvalid.
// One output register holds a finished result, so the next transaction is
// processed while the receiver stalls; the sequencer waits only when a
// second result is ready before the first is taken.
// Reset empties the cache (all valid bits cleared, occupancy zero) and sets
// the capacity to 16; no clearing pass is needed.
`timescale 1ns / 1ps

module lru_key_value_cache import lkv_pkg::*; #(
	parameter int ENTRIES = ENTRIES_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CAP_W-1:0]      cfg_wr_data,   // capacity_in_use
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [DATA_IN_W-1:0]  s_tdata,       // lookup_key, write_value
	input  logic                  s_tuser,       // mode
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [DATA_OUT_W-1:0] m_tdata        // found, read_value, evicted, evicted_key
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int AW = IW;

	logic             kv_rd_en;
	logic [IW-1:0]    kv_rd_addr;
	logic [KEY_W-1:0] kv_rd_key;
	logic [VAL_W-1:0] kv_rd_value;
	logic             kv_wr_en;
	logic [IW-1:0]    kv_wr_addr;
	logic [KEY_W-1:0] kv_wr_key;
	logic [VAL_W-1:0] kv_wr_value;
	logic             age_rd_en;
	logic [IW-1:0]    age_rd_addr;
	logic [AW-1:0]    age_rd_data;
	logic             age_wr_en;
	logic [IW-1:0]    age_wr_addr;
	logic [AW-1:0]    age_wr_data;
	logic             res_push;
	lkv_result_t      res_data;
	logic             res_ready;

	lkv_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.kv_rd_en    (kv_rd_en),
		.kv_rd_addr  (kv_rd_addr),
		.kv_rd_key   (kv_rd_key),
		.kv_rd_value (kv_rd_value),
		.kv_wr_en    (kv_wr_en),
		.kv_wr_addr  (kv_wr_addr),
		.kv_wr_key   (kv_wr_key),
		.kv_wr_value (kv_wr_value),
		.age_rd_en   (age_rd_en),
		.age_rd_addr (age_rd_addr),
		.age_rd_data (age_rd_data),
		.age_wr_en   (age_wr_en),
		.age_wr_addr (age_wr_addr),
		.age_wr_data (age_wr_data),
		.res_push    (res_push),
		.res_data    (res_data),
		.res_ready   (res_ready)
	);

	lkv_store #(.ENTRIES(ENTRIES)) u_store (
		.clk         (clk),
		.kv_rd_en    (kv_rd_en),
		.kv_rd_addr  (kv_rd_addr),
		.kv_rd_key   (kv_rd_key),
		.kv_rd_value (kv_rd_value),
		.kv_wr_en    (kv_wr_en),
		.kv_wr_addr  (kv_wr_addr),
		.kv_wr_key   (kv_wr_key),
		.kv_wr_value (kv_wr_value),
		.age_rd_en   (age_rd_en),
		.age_rd_addr (age_rd_addr),
		.age_rd_data (age_rd_data),
		.age_wr_en   (age_wr_en),
		.age_wr_addr (age_wr_addr),
		.age_wr_data (age_wr_data)
	);

	lkv_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_push  (res_push),
		.res_data  (res_data),
		.res_ready (res_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule
